### rtl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// RC4 keystream package
// Widths, sizes and register indexes shared by the keystream generator files.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int BYTE_W      = 8;
  localparam int TABLE_DEPTH = 256;
  localparam int TABLE_AW    = 8;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int KEY_LEN_W   = 4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [TABLE_AW-1:0]  tbl_addr_t;
  typedef logic [BYTE_W-1:0]    byte_t;

  localparam cfg_idx_t CFG_KEY_BYTES  = 2'd0;
  localparam cfg_idx_t CFG_KEY_LENGTH = 2'd1;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 4'd5;

  // Write and read request towards the permutation table.
  typedef struct packed {
    logic      we;
    tbl_addr_t waddr;
    byte_t     wdata;
    tbl_addr_t raddr;
  } tbl_req_t;

endpackage

### rtl/rc4_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered and returns the
// contents held before a write to the same address in the same cycle.
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/rc4_engine.sv
// ----------------------------------------------------------------------------
// RC4 sequencer
// Drives the permutation table through the key schedule and the keystream
// steps and holds the result register.
// ----------------------------------------------------------------------------
module rc4_engine #(
  parameter int MAX_KEY_BYTES = 8,
  parameter int KW            = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [MAX_KEY_BYTES*8-1:0]   key_bytes,
  input  logic [KW-1:0]                key_last,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_rekey,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rc4_pkg::BYTE_W-1:0]   out_keystream_byte
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_K_RD,
    ST_K_SUM,
    ST_K_WR_N,
    ST_K_WR_SUM,
    ST_G_RD_I,
    ST_G_SUM_J,
    ST_G_WR_I,
    ST_G_WR_J,
    ST_G_OUT,
    ST_FINISH
  } state_t;

  state_t              state_r, state_nxt;
  rc4_pkg::tbl_addr_t  cnt_r, cnt_nxt;
  rc4_pkg::tbl_addr_t  i_r, i_nxt;
  rc4_pkg::tbl_addr_t  j_r, j_nxt;
  logic [KW-1:0]       k_r, k_nxt;
  rc4_pkg::byte_t      si_r, si_nxt;
  rc4_pkg::byte_t      sj_r, sj_nxt;
  rc4_pkg::byte_t      res_r, res_nxt;
  rc4_pkg::byte_t      out_byte_r, out_byte_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                keyed_r, keyed_nxt;

  rc4_pkg::tbl_req_t   req;
  rc4_pkg::byte_t      rdata;
  rc4_pkg::byte_t      key_byte;
  rc4_pkg::tbl_addr_t  t_addr;
  rc4_pkg::byte_t      result;
  logic                out_free;

  rc4_ram #(
    .WIDTH (rc4_pkg::BYTE_W),
    .DEPTH (rc4_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .raddr (req.raddr),
    .rdata (rdata)
  );

  assign key_byte = key_bytes[k_r*8 +: 8];
  assign t_addr   = si_r + sj_r;
  // The j entry is written in the same cycle as the output read is issued,
  // so a hit on j is taken from the swap register instead of the table.
  assign result   = (t_addr == j_r) ? si_r : rdata;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    res_nxt       = res_r;
    out_byte_nxt  = out_byte_r;
    out_valid_nxt = out_valid_r;
    keyed_nxt     = keyed_r;
    req.we        = 1'b0;
    req.waddr     = cnt_r;
    req.wdata     = cnt_r;
    req.raddr     = cnt_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_rekey || !keyed_r) begin
            cnt_nxt   = '0;
            state_nxt = ST_INIT;
          end else begin
            state_nxt = ST_G_RD_I;
          end
        end
      end
      ST_INIT: begin
        req.we    = 1'b1;
        req.waddr = cnt_r;
        req.wdata = cnt_r;
        cnt_nxt   = cnt_r + 1'b1;
        j_nxt     = '0;
        k_nxt     = '0;
        if (cnt_r == rc4_pkg::tbl_addr_t'(rc4_pkg::TABLE_DEPTH - 1)) begin
          state_nxt = ST_K_RD;
        end
      end
      ST_K_RD: begin
        req.raddr = cnt_r;
        state_nxt = ST_K_SUM;
      end
      ST_K_SUM: begin
        si_nxt    = rdata;
        j_nxt     = j_r + rdata + key_byte;
        req.raddr = j_nxt;
        k_nxt     = (k_r == key_last) ? '0 : k_r + 1'b1;
        state_nxt = ST_K_WR_N;
      end
      ST_K_WR_N: begin
        req.we    = 1'b1;
        req.waddr = cnt_r;
        req.wdata = rdata;
        state_nxt = ST_K_WR_SUM;
      end
      ST_K_WR_SUM: begin
        req.we    = 1'b1;
        req.waddr = j_r;
        req.wdata = si_r;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == rc4_pkg::tbl_addr_t'(rc4_pkg::TABLE_DEPTH - 1)) begin
          i_nxt     = '0;
          j_nxt     = '0;
          keyed_nxt = 1'b1;
          state_nxt = ST_G_RD_I;
        end else begin
          state_nxt = ST_K_RD;
        end
      end
      ST_G_RD_I: begin
        i_nxt     = i_r + 1'b1;
        req.raddr = i_nxt;
        state_nxt = ST_G_SUM_J;
      end
      ST_G_SUM_J: begin
        si_nxt    = rdata;
        j_nxt     = j_r + rdata;
        req.raddr = j_nxt;
        state_nxt = ST_G_WR_I;
      end
      ST_G_WR_I: begin
        sj_nxt    = rdata;
        req.we    = 1'b1;
        req.waddr = i_r;
        req.wdata = rdata;
        state_nxt = ST_G_WR_J;
      end
      ST_G_WR_J: begin
        req.we    = 1'b1;
        req.waddr = j_r;
        req.wdata = si_r;
        req.raddr = t_addr;
        state_nxt = ST_G_OUT;
      end
      ST_G_OUT: begin
        if (out_free) begin
          out_byte_nxt  = result;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          res_nxt   = result;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_byte_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      keyed_r     <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      keyed_r     <= keyed_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
    end
    cnt_r      <= cnt_nxt;
    k_r        <= k_nxt;
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    res_r      <= res_nxt;
    out_byte_r <= out_byte_nxt;
  end

  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_keystream_byte = out_byte_r;

endmodule

### rtl/rc4_keystream_generator.sv
// Per beat: the keystream steps, preceded by the fill of all 256 table
// entries and the key schedule when a rekey is asked or none is held.
// Each keystream byte takes three dependent table reads and two swap writes;
// a new beat is accepted only in idle, once the last byte is in the output register.
// Reset: synchronous, active low; indices cleared, no key schedule held, so
// the first beat after reset always runs the schedule.
// ----------------------------------------------------------------------------
// RC4 keystream generator
// Key registers on a write port of their own, and the RC4 sequencer.
// ----------------------------------------------------------------------------
module rc4_keystream_generator #(
  parameter int MAX_KEY_BYTES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_rekey,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rc4_pkg::BYTE_W-1:0]     out_keystream_byte
);

  localparam int KEY_W = MAX_KEY_BYTES * 8;
  localparam int KW    = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  logic [KEY_W-1:0]              key_r, key_nxt;
  logic [rc4_pkg::KEY_LEN_W-1:0] len_r, len_nxt;
  logic [KW-1:0]                 key_last;

  always_comb begin
    key_nxt = key_r;
    len_nxt = len_r;
    if (cfg_valid) begin
      case (cfg_index)
        rc4_pkg::CFG_KEY_BYTES:  key_nxt = cfg_data[KEY_W-1:0];
        rc4_pkg::CFG_KEY_LENGTH: len_nxt = cfg_data[rc4_pkg::KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      len_r <= rc4_pkg::KEY_LEN_RESET;
    end else begin
      key_r <= key_nxt;
      len_r <= len_nxt;
    end
  end

  // A zero length behaves as one byte; lengths above the key store saturate.
  always_comb begin
    if (len_r == '0) begin
      key_last = '0;
    end else if (32'(len_r) > MAX_KEY_BYTES) begin
      key_last = KW'(MAX_KEY_BYTES - 1);
    end else begin
      key_last = KW'(len_r - 1'b1);
    end
  end

  assign cfg_ready = 1'b1;

  rc4_engine #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES),
    .KW            (KW)
  ) u_engine (
    .clk                (clk),
    .rst_n              (rst_n),
    .key_bytes          (key_r),
    .key_last           (key_last),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rekey           (in_rekey),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_keystream_byte (out_keystream_byte)
  );

endmodule
